/* rtl/pmr_pkg.sv */
`default_nettype none
package pmr_pkg;

    localparam int NumTermsDef = 27;
    localparam int TermIdxW    = 5;
    localparam int CoefW       = 48;
    localparam int CoordW      = 24;
    localparam int ValW        = 32;
    localparam int SumW        = 64;
    localparam int MonW        = 64;
    localparam int AccW        = 128;
    localparam int VW          = 96;

    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [1:0] CRD_X = 2'd0;
    localparam logic [1:0] CRD_A = 2'd1;
    localparam logic [1:0] CRD_Y = 2'd2;
    localparam logic [1:0] CRD_B = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_TERM, S_MON_CHK, S_MON_LOAD, S_COEF_LOAD, S_MUL_P, S_MUL_A,
        S_MUL_FIN, S_MON_DONE, S_COEF_DONE, S_FIN1, S_FIN2, S_FIN3, S_FIN4
    } pmr_state_t;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][1:0] f;
    } term_info_t;

    typedef struct packed {
        logic                latch_in;
        logic                mon_init;
        logic                mul_load;
        logic                mul_coef;
        logic                mul_prod;
        logic                mul_acc;
        logic                mul_fin;
        logic                mon_done;
        logic                sum_clear;
        logic                sum_add;
        logic                fin1;
        logic                fin2;
        logic                fin3;
        logic                fin4;
        logic [1:0]          step;
        logic [TermIdxW-1:0] k;
        logic [2:0]          j;
    } pmr_cmd_t;

    typedef struct packed {
        logic       term_en;
        logic [2:0] term_cnt;
        logic       out_busy;
    } pmr_status_t;

    typedef struct packed {
        logic [ValW-1:0] val;
        logic            ovf;
    } sat_t;

    function automatic term_info_t mk(input logic [2:0] cnt, input logic [1:0] f0,
                                      input logic [1:0] f1, input logic [1:0] f2,
                                      input logic [1:0] f3);
        term_info_t t;
        t.cnt  = cnt;
        t.f[0] = f0;
        t.f[1] = f1;
        t.f[2] = f2;
        t.f[3] = f3;
        return t;
    endfunction

    // factors in x, a, y, b order
    function automatic term_info_t term_info(input logic [TermIdxW-1:0] k);
        term_info_t t;
        case (k)
            5'd0:  t = mk(3'd0, CRD_X, CRD_X, CRD_X, CRD_X);
            5'd1:  t = mk(3'd1, CRD_Y, CRD_X, CRD_X, CRD_X);
            5'd2:  t = mk(3'd1, CRD_B, CRD_X, CRD_X, CRD_X);
            5'd3:  t = mk(3'd1, CRD_X, CRD_X, CRD_X, CRD_X);
            5'd4:  t = mk(3'd1, CRD_A, CRD_X, CRD_X, CRD_X);
            5'd5:  t = mk(3'd2, CRD_X, CRD_Y, CRD_X, CRD_X);
            5'd6:  t = mk(3'd2, CRD_A, CRD_Y, CRD_X, CRD_X);
            5'd7:  t = mk(3'd2, CRD_X, CRD_B, CRD_X, CRD_X);
            5'd8:  t = mk(3'd2, CRD_A, CRD_B, CRD_X, CRD_X);
            5'd9:  t = mk(3'd2, CRD_X, CRD_X, CRD_X, CRD_X);
            5'd10: t = mk(3'd2, CRD_X, CRD_A, CRD_X, CRD_X);
            5'd11: t = mk(3'd2, CRD_A, CRD_A, CRD_X, CRD_X);
            5'd12: t = mk(3'd3, CRD_Y, CRD_Y, CRD_Y, CRD_X);
            5'd13: t = mk(3'd3, CRD_Y, CRD_Y, CRD_B, CRD_X);
            5'd14: t = mk(3'd3, CRD_Y, CRD_B, CRD_B, CRD_X);
            5'd15: t = mk(3'd3, CRD_X, CRD_X, CRD_Y, CRD_X);
            5'd16: t = mk(3'd3, CRD_X, CRD_A, CRD_Y, CRD_X);
            5'd17: t = mk(3'd3, CRD_A, CRD_A, CRD_Y, CRD_X);
            5'd18: t = mk(3'd3, CRD_B, CRD_B, CRD_B, CRD_X);
            5'd19: t = mk(3'd3, CRD_X, CRD_X, CRD_B, CRD_X);
            5'd20: t = mk(3'd3, CRD_X, CRD_A, CRD_B, CRD_X);
            5'd21: t = mk(3'd3, CRD_A, CRD_A, CRD_B, CRD_X);
            5'd22: t = mk(3'd3, CRD_X, CRD_X, CRD_X, CRD_X);
            5'd23: t = mk(3'd3, CRD_X, CRD_X, CRD_A, CRD_X);
            5'd24: t = mk(3'd3, CRD_X, CRD_A, CRD_A, CRD_X);
            5'd25: t = mk(3'd3, CRD_A, CRD_A, CRD_A, CRD_X);
            5'd26: t = mk(3'd4, CRD_X, CRD_X, CRD_X, CRD_X);
            default: t = mk(3'd0, CRD_X, CRD_X, CRD_X, CRD_X);
        endcase
        return t;
    endfunction

    function automatic sat_t sat32(input logic [VW-1:0] v);
        sat_t s;
        if ((&v[VW-1:ValW-1]) || !(|v[VW-1:ValW-1]))
        begin
            s.val = v[ValW-1:0];
            s.ovf = 1'b0;
        end
        else
        begin
            s.val = v[VW-1] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
            s.ovf = 1'b1;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

/* rtl/pmr_req_if.sv */
`default_nettype none
interface pmr_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [4:0]  coef_index;
    logic [47:0] coef_value;
    logic [23:0] coord_x;
    logic [23:0] coord_a;
    logic [23:0] coord_y;
    logic [23:0] coord_b;
    logic [23:0] target_value;
    logic        last_sample;

    modport source (output valid, req_type, coef_index, coef_value, coord_x, coord_a,
                    coord_y, coord_b, target_value, last_sample, input ready);
    modport sink (input valid, req_type, coef_index, coef_value, coord_x, coord_a,
                  coord_y, coord_b, target_value, last_sample, output ready);
endinterface
`default_nettype wire

/* rtl/pmr_rsp_if.sv */
`default_nettype none
interface pmr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] fit_value;
    logic [31:0] residual;
    logic [63:0] sum_squares;
    logic        sum_valid;
    logic        saturated;

    modport source (output valid, fit_value, residual, sum_squares, sum_valid, saturated,
                    input ready);
    modport sink (input valid, fit_value, residual, sum_squares, sum_valid, saturated,
                  output ready);
endinterface
`default_nettype wire

/* rtl/pmr_ctrl.sv */
`default_nettype none
module pmr_ctrl #(
    parameter int NUM_TERMS = pmr_pkg::NumTermsDef
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic                req_type,
    output logic                     req_ready,
    input  wire pmr_pkg::pmr_status_t status,
    output pmr_pkg::pmr_cmd_t        cmd
);
    import pmr_pkg::*;

    pmr_state_t          state_reg, state_next;
    logic [TermIdxW-1:0] k_reg, k_next;
    logic [2:0]          j_reg, j_next;
    logic [1:0]          step_reg, step_next;
    logic                mode_reg, mode_next;
    logic                accept;
    logic                last_step;

    assign accept    = req_valid && req_ready;
    assign last_step = mode_reg ? (step_reg == 2'd3) : (step_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            step_reg  <= '0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            step_reg  <= step_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        step_next  = step_reg;
        mode_next  = mode_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type == REQ_SAMPLE)
                begin
                    state_next = S_TERM;
                    k_next     = '0;
                end
            end
            S_TERM:
            begin
                if (k_reg == TermIdxW'(NUM_TERMS))
                    state_next = S_FIN1;
                else if (!status.term_en)
                    k_next = k_reg + 1'b1;
                else
                begin
                    j_next     = 3'd1;
                    state_next = S_MON_CHK;
                end
            end
            S_MON_CHK:
                state_next = (j_reg >= status.term_cnt) ? S_COEF_LOAD : S_MON_LOAD;
            S_MON_LOAD:
            begin
                mode_next  = 1'b0;
                step_next  = 2'd0;
                state_next = S_MUL_P;
            end
            S_COEF_LOAD:
            begin
                mode_next  = 1'b1;
                step_next  = 2'd0;
                state_next = S_MUL_P;
            end
            S_MUL_P:
                state_next = S_MUL_A;
            S_MUL_A:
            begin
                if (last_step)
                    state_next = S_MUL_FIN;
                else
                begin
                    step_next  = mode_reg ? step_reg + 2'd1 : 2'd2;
                    state_next = S_MUL_P;
                end
            end
            S_MUL_FIN:
                state_next = mode_reg ? S_COEF_DONE : S_MON_DONE;
            S_MON_DONE:
            begin
                j_next     = j_reg + 3'd1;
                state_next = S_MON_CHK;
            end
            S_COEF_DONE:
            begin
                k_next     = k_reg + 1'b1;
                state_next = S_TERM;
            end
            S_FIN1:
                state_next = S_FIN2;
            S_FIN2:
                state_next = S_FIN3;
            S_FIN3:
                state_next = S_FIN4;
            S_FIN4:
            begin
                if (!status.out_busy)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready     = (state_reg == S_IDLE);
        cmd           = '0;
        cmd.k         = k_reg;
        cmd.j         = j_reg;
        cmd.step      = step_reg;
        cmd.mul_coef  = mode_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.latch_in  = accept;
                cmd.sum_clear = accept;
            end
            S_TERM:
                cmd.mon_init = 1'b1;
            S_MON_LOAD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_coef = 1'b0;
            end
            S_COEF_LOAD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_coef = 1'b1;
            end
            S_MUL_P:     cmd.mul_prod = 1'b1;
            S_MUL_A:     cmd.mul_acc  = 1'b1;
            S_MUL_FIN:   cmd.mul_fin  = 1'b1;
            S_MON_DONE:  cmd.mon_done = 1'b1;
            S_COEF_DONE: cmd.sum_add  = 1'b1;
            S_FIN1:      cmd.fin1     = 1'b1;
            S_FIN2:      cmd.fin2     = 1'b1;
            S_FIN3:      cmd.fin3     = 1'b1;
            S_FIN4:      cmd.fin4     = !status.out_busy;
            default:     cmd.latch_in = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/pmr_dp.sv */
`default_nettype none
module pmr_dp #(
    parameter int NUM_TERMS = pmr_pkg::NumTermsDef
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pmr_pkg::pmr_cmd_t    cmd,
    output pmr_pkg::pmr_status_t      status,
    input  wire logic                 cfg_wr_en,
    input  wire logic [NUM_TERMS-1:0] cfg_wr_data,
    input  wire logic                 req_type,
    input  wire logic [4:0]           coef_index,
    input  wire logic [47:0]          coef_value,
    input  wire logic [23:0]          coord_x,
    input  wire logic [23:0]          coord_a,
    input  wire logic [23:0]          coord_y,
    input  wire logic [23:0]          coord_b,
    input  wire logic [23:0]          target_value,
    input  wire logic                 last_sample,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output logic [31:0]               fit_value,
    output logic [31:0]               residual,
    output logic [63:0]               sum_squares,
    output logic                      sum_valid,
    output logic                      saturated
);
    import pmr_pkg::*;

    logic [CoefW-1:0]     coef_reg [NUM_TERMS];
    logic [CoordW-1:0]    coord_reg [4];
    logic [CoordW-1:0]    tgt_reg;
    logic                 last_reg;
    logic [NUM_TERMS-1:0] te_reg;
    logic [MonW-1:0]      m_reg;
    logic [63:0]          mag_a_reg, mag_b_reg;
    logic                 neg_reg;
    logic [63:0]          prod_reg;
    logic [1:0]           sh_reg;
    logic [AccW-1:0]      macc_reg;
    logic [AccW-1:0]      sum_reg;
    logic [VW-1:0]        v_reg;
    logic [ValW-1:0]      fit_reg, res_reg;
    logic                 sat_reg;
    logic [SumW-1:0]      sq_reg;
    logic [SumW-1:0]      acc_reg;
    logic                 ovf_seen_reg;
    logic                 rsp_valid_reg;
    logic [ValW-1:0]      out_fit_reg, out_res_reg;
    logic [SumW-1:0]      out_sum_reg;
    logic                 out_last_reg, out_sat_reg;

    term_info_t      ti;
    logic [MonW-1:0] a_sel, b_sel;
    logic [AccW-1:0] mon_rnd, sum_rnd;
    logic [VW-1:0]   diff;
    sat_t            fit_s, res_s;
    logic [ValW-1:0] res_mag;
    logic [SumW:0]   sum_new;
    logic            ovf_new;

    function automatic logic [MonW-1:0] sx_coord(input logic [CoordW-1:0] c);
        return {{(MonW-CoordW){c[CoordW-1]}}, c};
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    assign ti              = term_info(cmd.k);
    assign status.term_en  = te_reg[cmd.k];
    assign status.term_cnt = ti.cnt;
    assign status.out_busy = rsp_valid_reg && !rsp_ready;

    assign a_sel = cmd.mul_coef ? {{(MonW-CoefW){coef_reg[cmd.k][CoefW-1]}}, coef_reg[cmd.k]}
                                : m_reg;
    assign b_sel = cmd.mul_coef ? m_reg : sx_coord(coord_reg[ti.f[cmd.j[1:0]]]);

    assign mon_rnd = macc_reg + AccW'(2048);
    assign sum_rnd = sum_reg + (AccW'(1) << 31);
    assign diff    = v_reg - {{(VW-CoordW){tgt_reg[CoordW-1]}}, tgt_reg};
    assign fit_s   = sat32(v_reg);
    assign res_s   = sat32(diff);
    assign res_mag = res_reg[ValW-1] ? (ValW'(0) - res_reg) : res_reg;
    assign sum_new = {1'b0, acc_reg} + {1'b0, sq_reg};
    assign ovf_new = ovf_seen_reg || sat_reg || sum_new[SumW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TERMS; i++)
                coef_reg[i] <= '0;
            te_reg        <= '1;
            acc_reg       <= '0;
            ovf_seen_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                te_reg <= cfg_wr_data;
            if (cmd.latch_in && req_type == REQ_COEF &&
                coef_index < TermIdxW'(NUM_TERMS))
                coef_reg[coef_index] <= coef_value;
            if (cmd.fin4)
            begin
                rsp_valid_reg <= 1'b1;
                acc_reg       <= last_reg ? '0 : (sum_new[SumW] ? '1 : sum_new[SumW-1:0]);
                ovf_seen_reg  <= last_reg ? 1'b0 : ovf_new;
            end
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            coord_reg[CRD_X] <= coord_x;
            coord_reg[CRD_A] <= coord_a;
            coord_reg[CRD_Y] <= coord_y;
            coord_reg[CRD_B] <= coord_b;
            tgt_reg          <= target_value;
            last_reg         <= last_sample;
        end
        if (cmd.sum_clear)
            sum_reg <= '0;
        else if (cmd.sum_add)
            sum_reg <= sum_reg + macc_reg;
        if (cmd.mon_init)
            m_reg <= (ti.cnt == 3'd0) ? MonW'(4096) : sx_coord(coord_reg[ti.f[0]]);
        else if (cmd.mon_done)
            m_reg <= mon_rnd[MonW+11:12];
        if (cmd.mul_load)
        begin
            mag_a_reg <= mag64(a_sel);
            mag_b_reg <= mag64(b_sel);
            neg_reg   <= a_sel[MonW-1] ^ b_sel[MonW-1];
            macc_reg  <= '0;
        end
        else if (cmd.mul_acc)
            macc_reg <= macc_reg + ({64'd0, prod_reg} << {sh_reg, 5'd0});
        else if (cmd.mul_fin)
            macc_reg <= neg_reg ? (AccW'(0) - macc_reg) : macc_reg;
        if (cmd.mul_prod)
        begin
            prod_reg <= (cmd.step[1] ? mag_a_reg[63:32] : mag_a_reg[31:0]) *
                        (cmd.step[0] ? mag_b_reg[63:32] : mag_b_reg[31:0]);
            sh_reg   <= 2'(cmd.step[1]) + 2'(cmd.step[0]);
        end
        if (cmd.fin1)
            v_reg <= sum_rnd[AccW-1:32];
        if (cmd.fin2)
        begin
            fit_reg <= fit_s.val;
            res_reg <= res_s.val;
            sat_reg <= fit_s.ovf || res_s.ovf;
        end
        if (cmd.fin3)
            sq_reg <= SumW'(res_mag) * SumW'(res_mag);
        if (cmd.fin4)
        begin
            out_fit_reg  <= fit_reg;
            out_res_reg  <= res_reg;
            out_sum_reg  <= sum_new[SumW] ? '1 : sum_new[SumW-1:0];
            out_last_reg <= last_reg;
            out_sat_reg  <= ovf_new;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign fit_value   = out_fit_reg;
    assign residual    = out_res_reg;
    assign sum_squares = out_sum_reg;
    assign sum_valid   = out_last_reg;
    assign saturated   = out_sat_reg;

endmodule
`default_nettype wire

/* rtl/poly_map_residual_sumsq.sv */
// channel | dir | beat
// req     | in  | coefficient write or sample (req_type selects)
// rsp     | out | fit value, residual, sum of squares, flags; one per sample
// cfg     | in  | term_enable write, one cycle, no handshake
//
// a coefficient write is stored as it is accepted, in idle; a sample walks every
// term, and a disabled term only advances the term index
// a sample's length is set by the shared 32x32 multiplier: 2 partial products per
// monomial factor, 4 per coefficient product, each product then accumulated
// async reset clears coefficients, sum and flag; term_enable resets to all ones
// a sample's work completes while rsp stalls, then holds until the beat is taken
`default_nettype none
module poly_map_residual_sumsq #(
    parameter int NUM_TERMS = pmr_pkg::NumTermsDef
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    pmr_req_if.sink                   req,
    pmr_rsp_if.source                 rsp,
    input  wire logic                 cfg_wr_en,
    input  wire logic [NUM_TERMS-1:0] cfg_wr_data
);
    import pmr_pkg::*;

    pmr_cmd_t    cmd;
    pmr_status_t status;

    pmr_ctrl #(.NUM_TERMS(NUM_TERMS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pmr_dp #(.NUM_TERMS(NUM_TERMS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_type     (req.req_type),
        .coef_index   (req.coef_index),
        .coef_value   (req.coef_value),
        .coord_x      (req.coord_x),
        .coord_a      (req.coord_a),
        .coord_y      (req.coord_y),
        .coord_b      (req.coord_b),
        .target_value (req.target_value),
        .last_sample  (req.last_sample),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .fit_value    (rsp.fit_value),
        .residual     (rsp.residual),
        .sum_squares  (rsp.sum_squares),
        .sum_valid    (rsp.sum_valid),
        .saturated    (rsp.saturated)
    );

endmodule
`default_nettype wire

/* rtl/pmr_checker.sv */
`default_nettype none
module pmr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        req_type,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] rsp_fit_value,
    input wire logic [31:0] rsp_residual,
    input wire logic [63:0] rsp_sum_squares
);
    import pmr_pkg::*;

    logic [31:0] res_mag;
    logic [63:0] res_sq;

    assign res_mag = rsp_residual[31] ? (32'd0 - rsp_residual) : rsp_residual;
    assign res_sq  = 64'(res_mag) * 64'(res_mag);

    // stalled beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fit_value))
        else $error("rsp beat changed under stall");

    // a sample keeps the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_SAMPLE |=> !req_ready)
        else $error("req ready right after sample");

    // running sum includes this residual squared
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_sum_squares >= res_sq)
        else $error("sum of squares below residual square");

endmodule

bind poly_map_residual_sumsq pmr_checker u_pmr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_type        (req.req_type),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_fit_value   (rsp.fit_value),
    .rsp_residual    (rsp.residual),
    .rsp_sum_squares (rsp.sum_squares)
);
`default_nettype wire
